// ===== src/rmac_pkg.sv =====
// Shared types and codes for the accumulator machine core.
package rmac_pkg;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_HALTED = 3'd1,
    ST_BADPC  = 3'd2,
    ST_BREAK  = 3'd3,
    ST_BADOP  = 3'd4,
    ST_RANGE  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    OPN_EXEC  = 2'd0,
    OPN_WRITE = 2'd1,
    OPN_READ  = 2'd2,
    OPN_NONE  = 2'd3
  } operation_e;

  localparam logic [4:0] OP_CLOAD = 5'd12;
  localparam logic [4:0] OP_GOTO  = 5'd17;
  localparam logic [4:0] OP_JLE   = 5'd18;
  localparam logic [4:0] OP_JLT   = 5'd19;
  localparam logic [4:0] OP_JEQ   = 5'd20;
  localparam logic [4:0] OP_JGT   = 5'd21;
  localparam logic [4:0] OP_END   = 5'd23;

  typedef enum logic [2:0] {
    ALU_LOAD  = 3'd0,
    ALU_STORE = 3'd1,
    ALU_ADD   = 3'd2,
    ALU_SUB   = 3'd3,
    ALU_MULT  = 3'd4,
    ALU_DIV   = 3'd5
  } alu_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD1, S_RD1W, S_RD2, S_RD2W, S_EXEC, S_ITER, S_WB, S_OUT
  } state_e;

  // Request to the shared arithmetic unit.
  typedef struct packed {
    logic start;
    alu_e kind;
  } alu_req_t;

endpackage

// ===== src/rmac_ram.sv =====
// Generic single-port RAM with registered read.
module rmac_ram #(
  parameter int Width = 64,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // Write one entry when enabled and read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

// ===== src/rmac_alu.sv =====
// Shared arithmetic unit: load pass-through, add, sub, shift-add multiply and restoring divide.
module rmac_alu
  import rmac_pkg::*;
#(
  parameter int DataWidth = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  alu_req_t             req_i,
  input  logic [DataWidth-1:0] a_i,
  input  logic [DataWidth-1:0] b_i,
  output logic                 done_o,
  output logic [DataWidth-1:0] res_o
);
  localparam int CntW = $clog2(DataWidth + 1);

  logic                 busy_q, busy_d;
  alu_e                 kind_q, kind_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DataWidth-1:0] acc_q, acc_d;   // result; product or quotient while iterating
  logic [DataWidth-1:0] rem_q, rem_d;
  logic [DataWidth-1:0] opa_q, opa_d;   // multiplicand / dividend
  logic [DataWidth-1:0] opb_q, opb_d;   // multiplier / divisor
  logic                 done_d, done_q;
  logic [DataWidth:0]   trial;
  logic [DataWidth:0]   remsh;

  always_comb begin
    remsh = {rem_q, opa_q[DataWidth-1]};
    trial = remsh - {1'b0, opb_q};
  end

  // Sequence one bit per cycle for multiply and divide
  always_comb begin
    busy_d = busy_q; kind_d = kind_q; cnt_d = cnt_q; acc_d = acc_q;
    rem_d = rem_q; opa_d = opa_q; opb_d = opb_q; done_d = 1'b0;
    if (req_i.start) begin
      kind_d = req_i.kind;
      opa_d  = a_i;
      opb_d  = b_i;
      rem_d  = '0;
      cnt_d  = CntW'(DataWidth);
      case (req_i.kind)
        ALU_ADD:  begin acc_d = a_i + b_i; done_d = 1'b1; end
        ALU_SUB:  begin acc_d = a_i - b_i; done_d = 1'b1; end
        ALU_MULT: begin acc_d = '0; busy_d = 1'b1; end
        ALU_DIV:  begin
          if (b_i == '0) begin acc_d = '0; done_d = 1'b1; end
          else begin acc_d = '0; busy_d = 1'b1; end
        end
        default:  begin acc_d = b_i; done_d = 1'b1; end
      endcase
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (kind_q == ALU_MULT) begin
        if (opb_q[0]) acc_d = acc_q + opa_q;
        opa_d = opa_q << 1;
        opb_d = opb_q >> 1;
      end else begin
        opa_d = opa_q << 1;
        if (!trial[DataWidth]) begin
          rem_d = trial[DataWidth-1:0];
          acc_d = {acc_q[DataWidth-2:0], 1'b1};
        end else begin
          rem_d = remsh[DataWidth-1:0];
          acc_d = {acc_q[DataWidth-2:0], 1'b0};
        end
      end
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      kind_q <= ALU_LOAD;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      kind_q <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    opa_q <= opa_d;
    opb_q <= opb_d;
  end

  assign done_o = done_q;
  assign res_o  = acc_q;
endmodule

// ===== src/ram_machine_accumulator_core.sv =====
// Accumulator machine core: runs one instruction or debug access per beat.
// Path of a beat: jumps, end and rejected beats go S_RD1 to S_OUT; debug adds S_RD1W; direct operands
// pass S_RD1W, indirect ones also S_RD2 and S_RD2W, then S_EXEC (a store ends there); constant forms
// go S_RD1 to S_EXEC; loads and arithmetic add S_ITER and S_WB (the shared unit does mult and div
// one bit per cycle; divide by zero is short). One beat in flight: next taken after the result leaves.
// Reset: a clearing pass zeroes all NUM_REGS registers, no beat taken; pc 0, running, length 0.
module ram_machine_accumulator_core
  import rmac_pkg::*;
#(
  parameter int NUM_REGS   = 4096,
  parameter int DATA_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [4:0]  opcode_i,
  input  logic [15:0] operand_i,
  input  logic [15:0] jump_target_i,
  input  logic        breakpoint_set_i,
  input  logic [11:0] reg_index_i,
  input  logic [63:0] write_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] next_pc_o,
  output logic [63:0] accumulator_o,
  output logic [63:0] read_data_o
);
  localparam int AW = $clog2(NUM_REGS);
  localparam int DW = DATA_WIDTH;

  state_e state_q, state_d;
  logic [15:0] plen_q, pc_q, pc_d;
  logic run_q, run_d;
  logic [DW-1:0] acc_q, acc_d;
  logic [AW:0] clr_q, clr_d;

  // captured beat
  logic [1:0]  opn_q;
  logic [4:0]  opc_q;
  logic [15:0] opd_q, tgt_q;
  logic        brk_q;
  logic [11:0] ridx_q;
  logic [DW-1:0] wval_q;

  logic [AW-1:0] addr_q, addr_d;
  logic [2:0] st_q, st_d;
  logic [DW-1:0] rd_q, rd_d;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [DW-1:0] ram_wdata, ram_rdata;
  alu_req_t req;
  logic alu_done;
  logic [DW-1:0] alu_b, alu_res;

  logic accept;
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  rmac_ram #(.Width(DW), .Depth(NUM_REGS)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  rmac_alu #(.DataWidth(DW)) u_alu (
    .clk_i, .rst_ni, .req_i(req), .a_i(acc_q), .b_i(alu_b),
    .done_o(alu_done), .res_o(alu_res)
  );

  logic [4:0] base;
  logic [2:0] kind;
  logic [15:0] pc1;
  logic [DW-1:0] cval;
  logic dir_oor, rd_oor, cond, dbg_oor;

  always_comb begin
    pc1  = pc_q + 16'd1;
    base = (opc_q >= 5'd6) ? opc_q - 5'd6 : opc_q;
    kind = (opc_q >= OP_CLOAD) ? ((opc_q == OP_CLOAD) ? 3'd0 : 3'(opc_q - 5'd11))
                               : base[2:0];
    cval = DW'(opd_q);
    dir_oor = ({16'd0, opd_q} >= 32'(NUM_REGS));
    rd_oor  = (65'(ram_rdata) >= 65'(NUM_REGS));
    dbg_oor = ({20'd0, ridx_q} >= 32'(NUM_REGS));
    case (opc_q)
      OP_JLE:  cond = acc_q <= cval;
      OP_JLT:  cond = acc_q < cval;
      OP_JEQ:  cond = acc_q == cval;
      OP_JGT:  cond = acc_q > cval;
      default: cond = acc_q >= cval;
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == (AW+1)'(NUM_REGS - 1)) state_d = S_IDLE;
      S_IDLE:  if (accept) state_d = S_RD1;
      S_RD1: begin
        if (opn_q == OPN_EXEC) begin
          if (!run_q || pc_q >= plen_q || brk_q || opc_q > OP_END) state_d = S_OUT;
          else if (opc_q <= 5'd11) state_d = dir_oor ? S_OUT : S_RD1W;
          else if (opc_q < OP_GOTO) state_d = S_EXEC;
          else state_d = S_OUT;
        end else if ((opn_q == OPN_WRITE || opn_q == OPN_READ) && !dbg_oor) begin
          state_d = S_RD1W;
        end else state_d = S_OUT;
      end
      S_RD1W: begin
        if (opn_q != OPN_EXEC) state_d = S_OUT;
        else if (opc_q >= 5'd6) state_d = rd_oor ? S_OUT : S_RD2;
        else state_d = S_EXEC;
      end
      S_RD2:  state_d = S_RD2W;
      S_RD2W: state_d = S_EXEC;
      S_EXEC: state_d = (kind == ALU_STORE) ? S_OUT : S_ITER;
      S_ITER: if (alu_done) state_d = S_WB;
      S_WB:   state_d = S_OUT;
      S_OUT:  if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    pc_d = pc_q; run_d = run_q; acc_d = acc_q; clr_d = clr_q;
    addr_d = addr_q; st_d = st_q; rd_d = rd_q;
    ram_we = 1'b0; ram_addr = addr_q; ram_wdata = '0;
    req.start = 1'b0; req.kind = alu_e'(kind);
    alu_b = (opc_q >= OP_CLOAD) ? cval : ram_rdata;
    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1; ram_addr = clr_q[AW-1:0];
        clr_d = clr_q + 1'b1;
      end
      S_IDLE: begin
        st_d = ST_OK; rd_d = '0;
      end
      S_RD1: begin
        if (opn_q == OPN_EXEC) begin
          addr_d = opd_q[AW-1:0];
          ram_addr = opd_q[AW-1:0];
          if (!run_q) st_d = ST_HALTED;
          else if (pc_q >= plen_q) st_d = ST_BADPC;
          else if (brk_q) st_d = ST_BREAK;
          else if (opc_q > OP_END) st_d = ST_BADOP;
          else if (opc_q <= 5'd11) begin
            if (dir_oor) st_d = ST_RANGE;
          end else if (opc_q == OP_GOTO) pc_d = opd_q;
          else if (opc_q == OP_END) begin run_d = 1'b0; st_d = ST_HALTED; end
          else if (opc_q > OP_GOTO) pc_d = cond ? tgt_q : pc1;
        end else if (opn_q == OPN_WRITE || opn_q == OPN_READ) begin
          addr_d = AW'(ridx_q);
          ram_addr = AW'(ridx_q);
          if (dbg_oor) st_d = ST_RANGE;
          else if (opn_q == OPN_WRITE) begin
            ram_we = 1'b1; ram_wdata = wval_q;
            if (AW'(ridx_q) == '0) acc_d = wval_q;
          end
        end
      end
      S_RD1W: begin
        if (opn_q == OPN_READ) rd_d = ram_rdata;
        else if (opn_q == OPN_EXEC && opc_q >= 5'd6) begin
          if (rd_oor) st_d = ST_RANGE;
          else addr_d = ram_rdata[AW-1:0];
        end
      end
      S_RD2: ram_addr = addr_q;
      S_EXEC: begin
        if (kind == ALU_STORE) begin
          ram_we = 1'b1; ram_wdata = acc_q;
          if (addr_q == '0) acc_d = acc_q;
          pc_d = pc1;
        end else req.start = 1'b1;
      end
      S_WB: begin
        acc_d = alu_res; ram_we = 1'b1; ram_addr = '0; ram_wdata = alu_res;
        pc_d = pc1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      plen_q  <= '0;
      pc_q    <= '0;
      run_q   <= 1'b1;
      acc_q   <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      run_q   <= run_d;
      acc_q   <= acc_d;
      clr_q   <= clr_d;
      if (cfg_we_i) plen_q <= cfg_wdata_i;
    end
  end

  // Capture the beat and hold working values
  always_ff @(posedge clk_i) begin
    if (accept) begin
      opn_q  <= operation_i;
      opc_q  <= opcode_i;
      opd_q  <= operand_i;
      tgt_q  <= jump_target_i;
      brk_q  <= breakpoint_set_i;
      ridx_q <= reg_index_i;
      wval_q <= write_value_i[DW-1:0];
    end
    addr_q <= addr_d;
    st_q   <= st_d;
    rd_q   <= rd_d;
  end

  assign status_o      = st_q;
  assign next_pc_o     = pc_q;
  assign accumulator_o = 64'(acc_q);
  assign read_data_o   = 64'(rd_q);
endmodule

// ===== tb/sv/tb_ram_machine_accumulator_core.sv =====
// Self-checking testbench for the accumulator machine core with a built-in predictor.
module tb_ram_machine_accumulator_core;
  import rmac_pkg::*;

  localparam int NREGS      = 4096;
  localparam int WATCH_MAX  = 20000;
  localparam int QUIET_TAIL = 200;

  // Opcode names not given by the package
  localparam logic [4:0] OP_LOAD  = 5'd0;
  localparam logic [4:0] OP_STORE = 5'd1;
  localparam logic [4:0] OP_ADD   = 5'd2;
  localparam logic [4:0] OP_SUB   = 5'd3;
  localparam logic [4:0] OP_MULT  = 5'd4;
  localparam logic [4:0] OP_DIV   = 5'd5;
  localparam logic [4:0] OP_LOADI = 5'd6;
  localparam logic [4:0] OP_STORI = 5'd7;
  localparam logic [4:0] OP_CADD  = 5'd13;
  localparam logic [4:0] OP_CSUB  = 5'd14;
  localparam logic [4:0] OP_CMULT = 5'd15;
  localparam logic [4:0] OP_CDIV  = 5'd16;
  localparam logic [4:0] OP_JGE   = 5'd22;
  localparam logic [4:0] OP_BAD   = 5'd31;

  typedef struct {
    operation_e  operation;
    logic [4:0]  opcode;
    logic [15:0] operand;
    logic [15:0] jump_target;
    logic        brk;
    logic [11:0] reg_index;
    logic [63:0] write_value;
  } instr_t;

  typedef struct {
    status_e     status;
    logic [15:0] next_pc;
    logic [63:0] acc;
    logic [63:0] read_data;
  } outcome_t;

  typedef struct {
    instr_t   ins;
    bit       typed;
    outcome_t res;
  } row_t;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i, in_stall_o;
  logic [1:0]  operation_i;
  logic [4:0]  opcode_i;
  logic [15:0] operand_i, jump_target_i;
  logic        breakpoint_set_i;
  logic [11:0] reg_index_i;
  logic [63:0] write_value_i;
  logic        out_valid_o, out_stall_i;
  logic [2:0]  status_o;
  logic [15:0] next_pc_o;
  logic [63:0] accumulator_o, read_data_o;

  ram_machine_accumulator_core i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .operation_i, .opcode_i, .operand_i, .jump_target_i, .breakpoint_set_i,
    .reg_index_i, .write_value_i, .out_valid_o, .out_stall_i, .status_o,
    .next_pc_o, .accumulator_o, .read_data_o
  );

  // Machine state mirrored by the predictor
  logic [63:0] mirror_regs [NREGS];
  logic [15:0] mirror_pc;
  bit          mirror_running;
  logic [15:0] mirror_len;

  outcome_t pending_results[$];
  int  mismatch_count = 0;
  int  beats_sent = 0;
  bit  quiet = 0;
  bit  long_hold_done = 0;
  int  idle_cycles = 0;

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // Apply one arithmetic step or store to the mirrored accumulator and registers
  function automatic void mirror_alu(int kind, logic [63:0] val, int addr);
    logic [63:0] a;
    a = mirror_regs[0];
    case (kind)
      0: a = val;
      1: begin
        mirror_regs[addr] = a;
        return;
      end
      2: a = a + val;
      3: a = a - val;
      4: a = a * val;
      default: a = (val != 0) ? a / val : 64'd0;
    endcase
    mirror_regs[0] = a;
  endfunction

  // Work out the outcome of one beat and advance the mirrored state
  function automatic outcome_t machine_step(instr_t b);
    outcome_t o;
    logic [63:0] idx, acc, cmp;
    logic [15:0] pc1;
    bit cond;
    int cmap[5] = '{0, 2, 3, 4, 5};
    o.status = ST_OK;
    o.read_data = '0;
    acc = mirror_regs[0];
    pc1 = mirror_pc + 16'd1;
    cmp = {48'd0, b.operand};
    if (b.operation == OPN_EXEC) begin
      if (!mirror_running) o.status = ST_HALTED;
      else if (mirror_pc >= mirror_len) o.status = ST_BADPC;
      else if (b.brk) o.status = ST_BREAK;
      else if (b.opcode > OP_END) o.status = ST_BADOP;
      else if (b.opcode <= 5'd11) begin
        idx = cmp;
        if (idx >= NREGS) o.status = ST_RANGE;
        else begin
          if (b.opcode >= OP_LOADI) idx = mirror_regs[idx];
          if (idx >= NREGS) o.status = ST_RANGE;
          else begin
            mirror_alu(b.opcode % 6, mirror_regs[idx], int'(idx));
            mirror_pc = pc1;
          end
        end
      end else if (b.opcode < OP_GOTO) begin
        mirror_alu(cmap[b.opcode - OP_CLOAD], cmp, 0);
        mirror_pc = pc1;
      end else if (b.opcode == OP_GOTO) begin
        mirror_pc = b.operand;
      end else if (b.opcode < OP_END) begin
        case (b.opcode)
          OP_JLE: cond = acc <= cmp;
          OP_JLT: cond = acc < cmp;
          OP_JEQ: cond = acc == cmp;
          OP_JGT: cond = acc > cmp;
          default: cond = acc >= cmp;
        endcase
        mirror_pc = cond ? b.jump_target : pc1;
      end else begin
        mirror_running = 0;
        o.status = ST_HALTED;
      end
    end else if (b.operation == OPN_WRITE) begin
      mirror_regs[b.reg_index] = b.write_value;
    end else if (b.operation == OPN_READ) begin
      o.read_data = mirror_regs[b.reg_index];
    end
    o.next_pc = mirror_pc;
    o.acc = mirror_regs[0];
    return o;
  endfunction

  // Offer one beat, hold it until taken, then queue its expected outcome
  task automatic send_beat(instr_t b, bit typed, outcome_t typed_res);
    outcome_t o;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    operation_i      <= b.operation;
    opcode_i         <= b.opcode;
    operand_i        <= b.operand;
    jump_target_i    <= b.jump_target;
    breakpoint_set_i <= b.brk;
    reg_index_i      <= b.reg_index;
    write_value_i    <= b.write_value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    o = machine_step(b);
    pending_results.push_back(typed ? typed_res : o);
    beats_sent++;
  endtask

  // Drain, then write program_length while the core is idle
  task automatic set_length(logic [15:0] len);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    mirror_len = len;
  endtask

  function automatic instr_t random_instr();
    instr_t b;
    int r, span;
    r = $urandom_range(0, 99);
    span = (mirror_len > 16'd56000) ? 60000 : int'(mirror_len) + int'(mirror_len) / 8 + 4;
    b.operation   = (r < 72) ? OPN_EXEC : (r < 85) ? OPN_WRITE : (r < 96) ? OPN_READ : OPN_NONE;
    b.opcode      = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(24, 31))
                                                 : 5'($urandom_range(0, 22));
    r = $urandom_range(0, 9);
    b.operand     = (r < 7) ? 16'($urandom_range(0, 15)) :
                    (r < 9) ? 16'($urandom_range(0, 4095)) : 16'($urandom);
    if (b.opcode == OP_GOTO) b.operand = 16'($urandom_range(0, span));
    b.jump_target = 16'($urandom_range(0, span));
    b.brk         = ($urandom_range(0, 19) == 0);
    b.reg_index   = $urandom_range(0, 1) ? 12'($urandom_range(0, 15)) : 12'($urandom);
    b.write_value = $urandom_range(0, 1) ? 64'($urandom_range(0, 15))
                                         : {32'($urandom), 32'($urandom)};
    return b;
  endfunction

  function automatic row_t mk(operation_e opn, logic [4:0] opc, logic [15:0] opd,
                              logic [11:0] ridx, logic [63:0] wval, logic brk = 0,
                              logic [15:0] tgt = 16'd0);
    row_t r;
    r.ins = '{opn, opc, opd, tgt, brk, ridx, wval};
    r.typed = 0;
    r.res = '{ST_OK, 16'd0, 64'd0, 64'd0};
    return r;
  endfunction

  function automatic row_t mkt(row_t r, status_e st, logic [15:0] pc, logic [63:0] acc,
                               logic [63:0] rd);
    r.typed = 1;
    r.res = '{st, pc, acc, rd};
    return r;
  endfunction

  // Receiver: random stall bursts plus one long hold
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && beats_sent >= 300) begin
        long_hold_done = 1;
        out_stall_i <= 1'b1;
        repeat (200) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(0, 2)) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat status=%0d pc=%0d", $time, status_o, next_pc_o);
        mismatch_count++;
      end else begin
        e = pending_results.pop_front();
        if (status_o !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, status_o);
          mismatch_count++;
        end
        if (next_pc_o !== e.next_pc) begin
          $display("%0t: next_pc exp %0d got %0d", $time, e.next_pc, next_pc_o);
          mismatch_count++;
        end
        if (accumulator_o !== e.acc) begin
          $display("%0t: accumulator exp %h got %h", $time, e.acc, accumulator_o);
          mismatch_count++;
        end
        if (read_data_o !== e.read_data) begin
          $display("%0t: read_data exp %h got %h", $time, e.read_data, read_data_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCH_MAX) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    int lens[5] = '{65535, 5000, 37, 1, 65535};
    outcome_t none;
    none = '{ST_OK, 16'd0, 64'd0, 64'd0};
    rst_ni = 0; cfg_we_i = 0; cfg_wdata_i = 0; in_valid_i = 0;
    operation_i = 0; opcode_i = 0; operand_i = 0; jump_target_i = 0;
    breakpoint_set_i = 0; reg_index_i = 0; write_value_i = 0;
    foreach (mirror_regs[i]) mirror_regs[i] = '0;
    mirror_pc = 0; mirror_running = 1; mirror_len = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with program_length still at reset value
    rows.push_back(mkt(mk(OPN_EXEC, OP_LOAD, 16'd0, 12'd0, 64'd0), ST_BADPC, 0, 0, 0));
    rows.push_back(mkt(mk(OPN_READ, OP_LOAD, 16'd0, 12'd4095, 64'd0), ST_OK, 0, 0, 0));
    rows.push_back(mkt(mk(OPN_WRITE, OP_LOAD, 16'd0, 12'd4095, '1), ST_OK, 0, 0, 0));
    rows.push_back(mkt(mk(OPN_READ, OP_LOAD, 16'd0, 12'd4095, 64'd0), ST_OK, 0, 0, '1));
    rows.push_back(mkt(mk(OPN_NONE, OP_LOAD, 16'd0, 12'd0, 64'd0), ST_OK, 0, 0, 0));
    foreach (rows[i]) send_beat(rows[i].ins, rows[i].typed, rows[i].res);
    rows.delete();

    set_length(16'hFFFF);
    rows.push_back(mk(OPN_WRITE, OP_LOAD, 16'd0, 12'd1, 64'd5));
    rows.push_back(mk(OPN_WRITE, OP_LOAD, 16'd0, 12'd2, '1));
    rows.push_back(mkt(mk(OPN_EXEC, OP_CLOAD, 16'hFFFF, 12'd0, 64'd0), ST_OK, 1, 64'hFFFF, 0));
    rows.push_back(mk(OPN_EXEC, OP_ADD, 16'd2, 12'd0, 64'd0));
    rows.push_back(mk(OPN_EXEC, OP_SUB, 16'd1, 12'd0, 64'd0));
    rows.push_back(mk(OPN_EXEC, OP_MULT, 16'd2, 12'd0, 64'd0));
    rows.push_back(mk(OPN_EXEC, OP_DIV, 16'd1, 12'd0, 64'd0));
    rows.push_back(mk(OPN_EXEC, OP_STORE, 16'd3, 12'd0, 64'd0));
    rows.push_back(mk(OPN_EXEC, OP_LOADI, 16'd1, 12'd0, 64'd0));
    rows.push_back(mk(OPN_EXEC, OP_STORI, 16'd1, 12'd0, 64'd0));
    rows.push_back(mk(OPN_EXEC, OP_CDIV, 16'd0, 12'd0, 64'd0));
    rows.push_back(mk(OPN_EXEC, OP_CADD, 16'd9, 12'd0, 64'd0));
    rows.push_back(mk(OPN_EXEC, OP_CSUB, 16'd3, 12'd0, 64'd0));
    rows.push_back(mk(OPN_EXEC, OP_CMULT, 16'd7, 12'd0, 64'd0));
    rows.push_back(mk(OPN_EXEC, OP_LOAD, 16'd0, 12'd0, 64'd0, 1'b1));
    rows.push_back(mk(OPN_EXEC, OP_BAD, 16'd0, 12'd0, 64'd0));
    rows.push_back(mk(OPN_EXEC, OP_LOAD, 16'd4096, 12'd0, 64'd0));
    rows.push_back(mk(OPN_EXEC, OP_LOADI, 16'd2, 12'd0, 64'd0));
    rows.push_back(mk(OPN_EXEC, OP_GOTO, 16'd100, 12'd0, 64'd0));
    rows.push_back(mk(OPN_EXEC, OP_JLE, 16'd42, 12'd0, 64'd0, 1'b0, 16'd200));
    rows.push_back(mk(OPN_EXEC, OP_JLT, 16'd42, 12'd0, 64'd0, 1'b0, 16'd300));
    rows.push_back(mk(OPN_EXEC, OP_JEQ, 16'd42, 12'd0, 64'd0, 1'b0, 16'd400));
    rows.push_back(mk(OPN_EXEC, OP_JGT, 16'd42, 12'd0, 64'd0, 1'b0, 16'd500));
    rows.push_back(mk(OPN_EXEC, OP_JGE, 16'hFFFF, 12'd0, 64'd0, 1'b0, 16'd600));
    foreach (rows[i]) send_beat(rows[i].ins, rows[i].typed, rows[i].res);

    // Random phases over several program lengths
    foreach (lens[p]) begin
      set_length(16'(lens[p]));
      for (int n = 0; n < 255; n++) begin
        if (p == 1 && n == 100) begin
          // Pause the sender until every result has come back
          @(negedge clk_i);
          in_valid_i <= 1'b0;
          wait (pending_results.size() == 0);
        end
        if (p == 4 && n >= 255 - QUIET_TAIL) quiet = 1;
        send_beat(random_instr(), 0, none);
      end
    end

    // Halt the machine, then show it stays halted while debug access works
    send_beat('{OPN_EXEC, OP_END, 16'd0, 16'd0, 1'b0, 12'd0, 64'd0}, 0, none);
    send_beat('{OPN_EXEC, OP_CLOAD, 16'd7, 16'd0, 1'b0, 12'd0, 64'd0}, 0, none);
    send_beat('{OPN_WRITE, OP_LOAD, 16'd0, 16'd0, 1'b0, 12'd0, 64'd77}, 0, none);
    send_beat('{OPN_READ, OP_LOAD, 16'd0, 16'd0, 1'b0, 12'd0, 64'd0}, 0, none);
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== ram_machine_accumulator_core.f =====
src/rmac_pkg.sv
src/rmac_ram.sv
src/rmac_alu.sv
src/ram_machine_accumulator_core.sv
tb/sv/tb_ram_machine_accumulator_core.sv
